/* design/assert_macros.svh */
// Assertion macros shared by the RTL. Define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Checks a property on every rising clock edge outside reset.
`define AIP_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("aip assertion failed");

// Checks that a condition never holds outside reset.
`define AIP_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("aip assertion failed");

`else

`define AIP_ASSERT(lbl, clk, rst_n, prop)
`define AIP_ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

/* design/aip_pkg.sv */
package aip_pkg;

  localparam int unsigned CharW = 8;
  localparam int unsigned ValW  = 64;
  localparam int unsigned WideW = ValW + 4;

  // Character codes with a special meaning.
  localparam logic [CharW-1:0] ChPlus   = 8'h2B;
  localparam logic [CharW-1:0] ChMinus  = 8'h2D;
  localparam logic [CharW-1:0] ChZero   = 8'h30;
  localparam logic [CharW-1:0] ChNine   = 8'h39;
  localparam logic [CharW-1:0] ChLowA   = 8'h61;
  localparam logic [CharW-1:0] ChLowF   = 8'h66;
  localparam logic [CharW-1:0] ChUpA    = 8'h41;
  localparam logic [CharW-1:0] ChUpF    = 8'h46;
  localparam logic [CharW-1:0] ChLowX   = 8'h78;
  localparam logic [CharW-1:0] ChUpX    = 8'h58;

  // Digit value that marks a character which is no digit at all.
  localparam logic [4:0] NotDigit = 5'd16;
  localparam logic [4:0] DecBase  = 5'd10;

  // Position counter codes; the counter saturates at two.
  localparam logic [1:0] PosFirst  = 2'd0;
  localparam logic [1:0] PosSecond = 2'd1;
  localparam logic [1:0] PosLater  = 2'd2;

  // One input item.
  typedef struct packed {
    logic [CharW-1:0] char_code;
    logic             char_valid;
    logic             last_char;
  } aip_char_t;

  // One result item.
  typedef struct packed {
    logic [ValW-1:0] parsed_bits;
    logic            parse_ok;
  } aip_result_t;

  // Parser state carried from one character to the next.
  typedef struct packed {
    logic [ValW-1:0] accumulator;
    logic [1:0]      char_position;
    logic            hex_base;
    logic            is_negative;
    logic            digit_seen;
    logic            failed;
  } aip_state_t;

  // Value of a digit character, or NotDigit for anything else.
  function automatic logic [4:0] digit_of(input logic [CharW-1:0] c);
    logic [CharW-1:0] diff;
    diff = '0;
    if (c >= ChZero && c <= ChNine) begin
      diff = c - ChZero;
      return diff[4:0];
    end else if (c >= ChLowA && c <= ChLowF) begin
      diff = c - ChLowA;
      return DecBase + diff[4:0];
    end else if (c >= ChUpA && c <= ChUpF) begin
      diff = c - ChUpA;
      return DecBase + diff[4:0];
    end
    return NotDigit;
  endfunction

endpackage

/* design/aip_if.sv */
// Character request channel.
interface aip_char_if
  import aip_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [CharW-1:0] char_code;
  logic             char_valid;
  logic             last_char;

  modport source (output valid, char_code, char_valid, last_char, input ready);
  modport sink   (input valid, char_code, char_valid, last_char, output ready);
endinterface

// Result request channel.
interface aip_result_if
  import aip_pkg::*;
();
  logic            valid;
  logic            ready;
  logic [ValW-1:0] parsed_bits;
  logic            parse_ok;

  modport source (output valid, parsed_bits, parse_ok, input ready);
  modport sink   (input valid, parsed_bits, parse_ok, output ready);
endinterface

// Configuration write channel for the signed mode register.
interface aip_cfg_if;
  logic valid;
  logic ready;
  logic signed_mode;

  modport source (output valid, signed_mode, input ready);
  modport sink   (input valid, signed_mode, output ready);
endinterface

/* design/aip_char_step.sv */
// Folds one character into the parser state.
module aip_char_step
  import aip_pkg::*;
(
  input  aip_state_t       state_i,
  input  logic [CharW-1:0] char_code_i,
  input  logic             char_valid_i,
  input  logic             signed_mode_i,
  output aip_state_t       state_o
);

  logic [4:0]       digit;
  logic             is_sign;
  logic             is_prefix;
  logic             bad_digit;
  logic [WideW-1:0] product;
  logic [WideW-1:0] sum;
  logic             overflow;

  // Classify the character against the current mode and position.
  always_comb begin
    digit     = digit_of(char_code_i);
    is_sign   = signed_mode_i && (state_i.char_position == PosFirst) &&
                (char_code_i == ChPlus || char_code_i == ChMinus);
    is_prefix = !signed_mode_i && (state_i.char_position == PosSecond) &&
                !state_i.hex_base && state_i.digit_seen &&
                (state_i.accumulator == '0) &&
                (char_code_i == ChLowX || char_code_i == ChUpX);
    bad_digit = (digit == NotDigit) || (!state_i.hex_base && digit >= DecBase);
  end

  // Multiply by the base with shifts and add the digit; any carry past
  // bit 63 is an overflow.
  always_comb begin
    if (state_i.hex_base) begin
      product = {state_i.accumulator, 4'h0};
    end else begin
      product = {1'b0, state_i.accumulator, 3'b000} +
                {3'b000, state_i.accumulator, 1'b0};
    end
    sum      = product + {{(WideW-4){1'b0}}, digit[3:0]};
    overflow = |sum[WideW-1:ValW];
  end

  // Next state.
  always_comb begin
    state_o = state_i;
    if (char_valid_i) begin
      if (!state_i.failed) begin
        if (is_sign) begin
          state_o.is_negative = (char_code_i == ChMinus);
        end else if (is_prefix) begin
          state_o.hex_base   = 1'b1;
          state_o.digit_seen = 1'b0;
        end else if (bad_digit || overflow) begin
          state_o.failed = 1'b1;
        end else begin
          state_o.accumulator = sum[ValW-1:0];
          state_o.digit_seen  = 1'b1;
        end
      end
      if (state_i.char_position != PosLater) begin
        state_o.char_position = state_i.char_position + 2'd1;
      end
    end
  end

endmodule

/* design/aip_finish.sv */
// Turns the final parser state into a result: range check and sign.
module aip_finish
  import aip_pkg::*;
(
  input  aip_state_t  state_i,
  input  logic        signed_mode_i,
  output aip_result_t result_o
);

  logic            ok;
  logic            out_of_range;
  logic [ValW-1:0] value;

  always_comb begin
    ok    = !state_i.failed && state_i.digit_seen;
    value = state_i.accumulator;
    // Negative numbers reach 2^63, positive ones stop at 2^63-1.
    if (state_i.is_negative) begin
      out_of_range = value[ValW-1] && (|value[ValW-2:0]);
    end else begin
      out_of_range = value[ValW-1];
    end
    if (ok && signed_mode_i) begin
      if (out_of_range) begin
        ok = 1'b0;
      end else if (state_i.is_negative) begin
        value = '0 - value;
      end
    end
    result_o.parse_ok    = ok;
    result_o.parsed_bits = ok ? value : '0;
  end

endmodule

/* design/ascii_integer_parser.sv */
// ASCII integer parser. Takes one character per cycle on char_i and gives
// one result on result_o for each item marked last_char. A character is
// registered on acceptance in the input register and folded into the parser
// state as it moves on, by a single 68-bit shift-add and carry check, so the
// block sustains one character per clock; a result is loaded into the result
// register as its last character moves on. Input only stalls when a result
// is pending in the output register, is not taken, and the registered item
// ends a string. The signed_mode register is written through cfg_i, which is
// always ready; write it only between strings for a defined result.
`include "assert_macros.svh"

module ascii_integer_parser
  import aip_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  aip_cfg_if.sink     cfg_i,
  aip_char_if.sink    char_i,
  aip_result_if.source result_o
);

  logic        signed_mode_q;
  logic        in_valid_q;
  aip_char_t   in_q;
  aip_state_t  state_q;
  aip_state_t  state_nx;
  aip_result_t res_d;
  aip_result_t res_q;
  logic        res_valid_q;
  logic        advance;
  logic        char_accept;
  logic        res_load;

  // Configuration register.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      signed_mode_q <= 1'b0;
    end else if (cfg_i.valid) begin
      signed_mode_q <= cfg_i.signed_mode;
    end
  end

  // The registered item moves on unless it ends a string and the result
  // register is still occupied and its result is not taken.
  assign advance     = in_valid_q && (!in_q.last_char || !res_valid_q || result_o.ready);
  assign res_load    = advance && in_q.last_char;
  assign char_i.ready = !in_valid_q || advance;
  assign char_accept = char_i.valid && char_i.ready;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (char_i.ready) begin
      in_valid_q <= char_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (char_accept) begin
      in_q.char_code  <= char_i.char_code;
      in_q.char_valid <= char_i.char_valid;
      in_q.last_char  <= char_i.last_char;
    end
  end

  aip_char_step u_step (
    .state_i       (state_q),
    .char_code_i   (in_q.char_code),
    .char_valid_i  (in_q.char_valid),
    .signed_mode_i (signed_mode_q),
    .state_o       (state_nx)
  );

  aip_finish u_finish (
    .state_i       (state_nx),
    .signed_mode_i (signed_mode_q),
    .result_o      (res_d)
  );

  // Parser state; cleared after every string.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (advance) begin
      state_q <= in_q.last_char ? '0 : state_nx;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (res_load) begin
      res_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      res_q <= res_d;
    end
  end

  assign result_o.valid       = res_valid_q;
  assign result_o.parsed_bits = res_q.parsed_bits;
  assign result_o.parse_ok    = res_q.parse_ok;

  // A failed parse never reports a nonzero value.
  `AIP_ASSERT_NEVER(a_fail_zero, clk_i, rst_ni,
    res_valid_q && !res_q.parse_ok && (res_q.parsed_bits != '0))
  // The parser state is clean after each string end.
  `AIP_ASSERT(a_state_clear, clk_i, rst_ni, res_load |=> (state_q == '0))
  // A held item is neither lost nor replaced.
  `AIP_ASSERT(a_in_hold, clk_i, rst_ni,
    (in_valid_q && !advance) |=> (in_valid_q && $stable(in_q)))
  // A result is only overwritten once the previous one has gone.
  `AIP_ASSERT_NEVER(a_res_overwrite, clk_i, rst_ni,
    res_load && res_valid_q && !result_o.ready)

endmodule

/* dv/tb_top.sv */
module tb_top;
  import aip_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Settings of the signed_mode register.
  localparam logic ModeUnsigned = 1'b0;
  localparam logic ModeSigned   = 1'b1;

  // Radixes, the marker for a non-digit and the magnitude limits.
  localparam logic [63:0] DecRadix = 64'd10;
  localparam logic [63:0] HexRadix = 64'd16;
  localparam logic [63:0] NoDigit  = 64'd16;
  localparam logic [63:0] MaxU64   = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] PosLimit = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] NegLimit = 64'h8000_0000_0000_0000;

  localparam int NumPhases     = 5;
  localparam int PhaseChars    = 330;
  localparam int CycleLimit    = 400000;
  localparam int MaxReports    = 10;
  localparam int PressureHold  = 400;
  localparam logic PhaseMode [NumPhases] =
    '{ModeUnsigned, ModeSigned, ModeUnsigned, ModeSigned, ModeSigned};

  // Sign and prefix characters, and characters on or next to the borders of the digit ranges.
  localparam logic [7:0] Tricky [16] = '{ChPlus, ChMinus, ChLowX, ChUpX, ChZero, ChNine,
                                         ChLowA, ChLowF, ChUpA, ChUpF, 8'h2F, 8'h3A,
                                         8'h40, 8'h47, 8'h60, 8'h67};

  // Tracks the parser state per string and holds the parses still to come out.
  class parse_scoreboard;
    logic        signed_mode;
    logic [63:0] accumulator;
    logic [1:0]  char_pos;
    logic        hex_base;
    logic        is_negative;
    logic        digit_seen;
    logic        failed;
    aip_result_t pending_parses[$];
    int          failures;

    function new();
      signed_mode = ModeUnsigned;
      failures = 0;
      clear_string();
    endfunction

    function void clear_string();
      accumulator = '0;
      char_pos    = PosFirst;
      hex_base    = 1'b0;
      is_negative = 1'b0;
      digit_seen  = 1'b0;
      failed      = 1'b0;
    endfunction

    function void set_mode(logic m);
      signed_mode = m;
    endfunction

    function logic [63:0] digit_value(logic [7:0] c);
      if (c >= ChZero && c <= ChNine) return 64'(c - ChZero);
      if (c >= ChLowA && c <= ChLowF) return 64'(c - ChLowA) + DecRadix;
      if (c >= ChUpA && c <= ChUpF) return 64'(c - ChUpA) + DecRadix;
      return NoDigit;
    endfunction

    // Folds one character into the running parse.
    function void take_char(logic [7:0] c);
      logic [63:0] radix;
      logic [63:0] d;
      if (!failed) begin
        if (signed_mode && char_pos == PosFirst && (c == ChPlus || c == ChMinus)) begin
          is_negative = (c == ChMinus);
        end else if (!signed_mode && char_pos == PosSecond && !hex_base && digit_seen &&
                     accumulator == 0 && (c == ChLowX || c == ChUpX)) begin
          hex_base   = 1'b1;
          digit_seen = 1'b0;
        end else begin
          radix = hex_base ? HexRadix : DecRadix;
          d = digit_value(c);
          if (d >= radix) begin
            failed = 1'b1;
          end else if (accumulator > (MaxU64 - d) / radix) begin
            failed = 1'b1;
          end else begin
            accumulator = accumulator * radix + d;
            digit_seen  = 1'b1;
          end
        end
      end
      char_pos = (char_pos >= PosLater) ? PosLater : char_pos + 2'd1;
    endfunction

    // Called for every accepted character request.
    function void note_char(aip_char_t item);
      aip_result_t parse;
      logic        ok;
      logic [63:0] value;
      if (item.char_valid) take_char(item.char_code);
      if (!item.last_char) return;
      ok = !failed && digit_seen;
      value = accumulator;
      if (ok && signed_mode) begin
        if (value > (is_negative ? NegLimit : PosLimit)) ok = 1'b0;
        else if (is_negative) value = -value;
      end
      parse.parsed_bits = ok ? value : '0;
      parse.parse_ok = ok;
      pending_parses.push_back(parse);
      clear_string();
    endfunction

    function void complain(string what, aip_result_t want, aip_result_t got);
      failures++;
      if (failures <= MaxReports)
        $display("tb_top: %s: expected bits=%h ok=%b, got bits=%h ok=%b", what,
                 want.parsed_bits, want.parse_ok, got.parsed_bits, got.parse_ok);
    endfunction

    // Called for every accepted result request.
    function void check_result(aip_result_t got);
      aip_result_t want;
      if (pending_parses.size() == 0) begin
        want = '0;
        complain("result with no string pending", want, got);
        return;
      end
      want = pending_parses.pop_front();
      if (got.parsed_bits !== want.parsed_bits || got.parse_ok !== want.parse_ok)
        complain("result mismatch", want, got);
    endfunction

    function void flush();
      while (pending_parses.size() != 0)
        complain("result never arrived", pending_parses.pop_front(), '0);
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  aip_cfg_if    cfg ();
  aip_char_if   chr ();
  aip_result_if res ();

  parse_scoreboard sb = new();

  int items_sent    = 0;
  bit src_calm      = 1'b0;
  int sink_idle_pct = 0;
  int sink_hold     = 0;

  ascii_integer_parser dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .char_i   (chr),
    .result_o (res)
  );

  initial begin : clock_gen
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Watchdog on the total run length.
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("tb_top: FAIL");
    $finish;
  end

  // Observe accepted requests on all three channels.
  always @(posedge clk_i) begin : request_watch
    aip_char_t   item;
    aip_result_t got;
    if (rst_ni) begin
      if (cfg.valid && cfg.ready) sb.set_mode(cfg.signed_mode);
      if (chr.valid && chr.ready) begin
        item.char_code  = chr.char_code;
        item.char_valid = chr.char_valid;
        item.last_char  = chr.last_char;
        sb.note_char(item);
      end
      if (res.valid && res.ready) begin
        got.parsed_bits = res.parsed_bits;
        got.parse_ok    = res.parse_ok;
        sb.check_result(got);
      end
    end
  end

  // Result receiver: random short and long stalls, plus a forced long hold.
  initial begin : result_sink
    int gap;
    gap = 0;
    res.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (sink_hold > 0) begin
        res.ready <= 1'b0;
        sink_hold--;
      end else if (gap > 0) begin
        res.ready <= 1'b0;
        gap--;
      end else begin
        res.ready <= 1'b1;
        if ($urandom_range(0, 99) < sink_idle_pct)
          gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      end
    end
  end

  function automatic int src_gap();
    int r;
    if (src_calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 25);
  endfunction

  // Offers one character request and waits until it is taken.
  task automatic send_item(input logic [7:0] code, input logic cv, input logic lst);
    int gap;
    gap = src_gap();
    if (gap > 0) begin
      chr.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    chr.valid      <= 1'b1;
    chr.char_code  <= code;
    chr.char_valid <= cv;
    chr.last_char  <= lst;
    @(posedge clk_i);
    while (!chr.ready) @(posedge clk_i);
    if (cv || lst) items_sent++;
  endtask

  // Sends a whole string. Sometimes empty items are slipped in, and sometimes the
  // string is closed by an empty last item instead of on its final character.
  task automatic send_text(input string t);
    bit pad;
    pad = ($urandom_range(0, 9) == 0) || t.len() == 0;
    src_calm = ($urandom_range(0, 4) == 0);
    for (int i = 0; i < t.len(); i++) begin
      if ($urandom_range(0, 19) == 0) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      send_item(t[i], 1'b1, !pad && i == t.len() - 1);
    end
    if (pad) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  task automatic write_mode(input logic m);
    cfg.valid       <= 1'b1;
    cfg.signed_mode <= m;
    @(posedge clk_i);
    while (!cfg.ready) @(posedge clk_i);
    cfg.valid <= 1'b0;
  endtask

  // Waits until every parse has come out and the pipeline has drained.
  task automatic settle();
    chr.valid <= 1'b0;
    repeat (4) @(posedge clk_i);
    while (sb.pending_parses.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [7:0] noise_char();
    if ($urandom_range(0, 1)) return Tricky[$urandom_range(0, 15)];
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic string mix_case(input string s);
    string t;
    t = s;
    for (int i = 0; i < t.len(); i++)
      if (t[i] >= ChLowA && t[i] <= ChLowF && $urandom_range(0, 1)) t[i] = t[i] - 8'd32;
    return t;
  endfunction

  function automatic logic [63:0] boundary_value();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return MaxU64;
      2: return MaxU64 - 64'd1;
      3: return PosLimit;
      4: return NegLimit;
      5: return NegLimit + 64'd1;
      6: return 64'h1999_9999_9999_9999;
      default: return 64'h1999_9999_9999_999A;
    endcase
  endfunction

  // Strings whose magnitude goes past 64 bits or past the signed limits.
  function automatic string oversize_text(input logic mode);
    case ($urandom_range(0, 3))
      0: return "18446744073709551616";
      1: return "99999999999999999999";
      2: return {$sformatf("%0d", rand64() | NegLimit), "7"};
      default: begin
        if (mode == ModeUnsigned) return "0x10000000000000000";
        return ($urandom_range(0, 1)) ? "-9223372036854775809" : "9223372036854775808";
      end
    endcase
  endfunction

  // A well-formed number in the notation of the given mode.
  function automatic string number_text(input logic mode);
    logic [63:0] mag;
    string       t;
    int          pick;
    pick = $urandom_range(0, 99);
    if (pick < 35) mag = $urandom_range(0, 999);
    else if (pick < 55) mag = boundary_value();
    else if (pick < 85) mag = rand64() >> $urandom_range(0, 63);
    else return oversize_text(mode);
    if (mode == ModeUnsigned && $urandom_range(0, 99) < 40) begin
      t = mix_case($sformatf("%0h", mag));
      if ($urandom_range(0, 3) == 0) t = {"0", t};
      if ($urandom_range(0, 1)) t = {"0x", t};
      else t = {"0X", t};
    end else begin
      t = $sformatf("%0d", mag);
      if ($urandom_range(0, 5) == 0) t = {"0", t};
      if (mode == ModeSigned) begin
        case ($urandom_range(0, 2))
          0: t = {"-", t};
          1: t = {"+", t};
          default: ;
        endcase
      end
    end
    return t;
  endfunction

  task automatic send_random_string(input logic mode);
    string t;
    int    r;
    int    n;
    r = $urandom_range(0, 99);
    if (r < 65) begin
      t = number_text(mode);
    end else if (r < 80) begin
      // A good number with one character replaced.
      t = number_text(mode);
      t[$urandom_range(0, t.len() - 1)] = noise_char();
    end else if (r < 95) begin
      t = "";
      n = $urandom_range(1, 5);
      repeat (n) t = {t, " "};
      for (int i = 0; i < n; i++) t[i] = noise_char();
    end else begin
      case ($urandom_range(0, 4))
        0: t = "";
        1: t = "0x";
        2: t = "0X";
        3: t = "+";
        default: t = "-";
      endcase
    end
    send_text(t);
  endtask

  initial begin : stimulus
    int phase_start;
    rst_ni          = 1'b0;
    cfg.valid       = 1'b0;
    cfg.signed_mode = 1'b0;
    chr.valid       = 1'b0;
    chr.char_code   = '0;
    chr.char_valid  = 1'b0;
    chr.last_char   = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int ph = 0; ph < NumPhases; ph++) begin
      write_mode(PhaseMode[ph]);
      case ($urandom_range(0, 2))
        0: sink_idle_pct = 0;
        1: sink_idle_pct = 15;
        default: sink_idle_pct = 45;
      endcase
      // Hold the receiver off long enough that the parser backs up and stalls.
      if (ph == 2) sink_hold = PressureHold;
      phase_start = items_sent;

      if (ph == 0) begin
        // Unsigned corner cases: empty string, bare prefix, upper-case prefix with
        // mixed-case hex digits, a digit outside the radix, and a prefix split by
        // an empty item.
        send_text("");
        send_text("0x");
        send_text("0XfF");
        send_text("9a");
        send_item(ChZero, 1'b1, 1'b0);
        send_item(8'hA5, 1'b0, 1'b0);
        send_item(ChLowX, 1'b1, 1'b0);
        send_item(ChZero + 8'd1, 1'b1, 1'b1);
      end else if (ph == 1) begin
        // Signed corner cases: bare sign, plus sign, minus zero, a second sign,
        // an x that only counts in unsigned mode, and a plain negative number.
        send_text("-");
        send_text("+7");
        send_text("-0");
        send_text("--1");
        send_text("1x");
        send_text("-9");
      end

      while (items_sent - phase_start < PhaseChars) send_random_string(PhaseMode[ph]);
      settle();
    end

    sb.flush();
    if (sb.failures == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
